[hw/rtl/box_sum_peak_locator_unit_assert.svh]
// assertion helpers for box_sum_peak_locator_unit.sv
`ifndef BOX_SUM_PEAK_LOCATOR_UNIT_ASSERT_SVH
`define BOX_SUM_PEAK_LOCATOR_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define BSPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define BSPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bspl_pkg.sv]
`default_nettype none

package bspl_pkg;

  // default geometry
  localparam int BOX_SIZE_DEF   = 10;
  localparam int POOL_SIZE_DEF  = 4;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CELL_BITS_DEF  = 8;

  // port field widths
  localparam int CELL_VALUE_W = 8;
  localparam int COORD_W      = 8;
  localparam int PEAK_SUM_W   = 15;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W      = 9;
  localparam int MIN_POP_W  = 15;

  localparam logic [DIM_W-1:0]     GRID_HEIGHT_RST = 9'd256;
  localparam logic [DIM_W-1:0]     GRID_WIDTH_RST  = 9'd256;
  localparam logic [MIN_POP_W-1:0] MIN_POP_RST     = 15'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_HEIGHT = 2'd0,
    REG_GRID_WIDTH  = 2'd1,
    REG_MIN_POP     = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

[hw/rtl/bspl_cell_if.sv]
`default_nettype none

interface bspl_cell_if import bspl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CELL_VALUE_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/bspl_result_if.sv]
`default_nettype none

interface bspl_result_if import bspl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [COORD_W-1:0]    window_row;
  logic [COORD_W-1:0]    window_col;
  logic                  leader_found;
  logic [COORD_W-1:0]    leader_row;
  logic [COORD_W-1:0]    leader_col;
  logic [PEAK_SUM_W-1:0] peak_sum;

  modport source (output valid, output window_row, output window_col, output leader_found,
                  output leader_row, output leader_col, output peak_sum, input ready);
  modport sink   (input valid, input window_row, input window_col, input leader_found,
                  input leader_row, input leader_col, input peak_sum, output ready);
endinterface

`default_nettype wire

[hw/rtl/bspl_line_mem.sv]
`default_nettype none

// one-port-write one-port-read line memory, registered read,
// bypass when the entry being read is written on the same edge
module bspl_line_mem #(
  parameter int Depth = 256,
  parameter int DataW = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [DataW-1:0]         wr_data_i,
  output logic      [DataW-1:0]         rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

[hw/rtl/box_sum_peak_locator_unit.sv]
`default_nettype none

// channel   dir  payload                                          transfer when
// cell_i    in   cell_value                                       valid & ready
// result_o  out  window_row/col, leader_found/row/col, peak_sum   valid & ready
// cfg       in   cfg_idx_i, cfg_data_i                            cfg_we_i
//
// one cell per clock sustained while no result is held back; a result passes stages 1 to 4
// and the output register after the cell that completes its pool window
// the cell line memory (one read and one write per cycle) sets that rate
// reset clears control, row window and scan position; memories are not cleared
// input stalls only while a finished result sits behind an untaken one
module box_sum_peak_locator_unit import bspl_pkg::*; #(
  parameter int BOX_SIZE   = BOX_SIZE_DEF,
  parameter int POOL_SIZE  = POOL_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bspl_cell_if.sink                  cell_i,
  bspl_result_if.source              result_o
);

  `include "box_sum_peak_locator_unit_assert.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CSW  = $clog2(BOX_SIZE * ((2 ** CELL_BITS) - 1) + 1);
  localparam int BW   = $clog2(BOX_SIZE * BOX_SIZE * ((2 ** CELL_BITS) - 1) + 1);
  localparam int IW   = $clog2(POOL_SIZE);
  localparam int KW   = BW + IW;
  localparam int WK   = BW + 2 * IW;
  localparam int CLW  = (BOX_SIZE - 1) * CELL_BITS;
  localparam int BLW  = (POOL_SIZE - 1) * BW;
  localparam int NP   = (BOX_SIZE + 1) / 2;
  localparam int SWC  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int SWR  = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int PW   = (BW > MIN_POP_W) ? BW : MIN_POP_W;

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0]     grid_height_q;
  logic [DIM_W-1:0]     grid_width_q;
  logic [MIN_POP_W-1:0] min_pop_q;
  logic                 restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_height_q <= GRID_HEIGHT_RST;
      grid_width_q  <= GRID_WIDTH_RST;
      min_pop_q     <= MIN_POP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i[DIM_W-1:0];
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_MIN_POP:     min_pop_q     <= cfg_data_i[MIN_POP_W-1:0];
        default: ;
      endcase
    end
  end

  // a size write starts a new grid
  assign restart = cfg_we_i && ((cfg_reg_e'(cfg_idx_i) == REG_GRID_HEIGHT) ||
                                (cfg_reg_e'(cfg_idx_i) == REG_GRID_WIDTH));

  // last column / row with the size clamped to 1..max
  logic [SWC-1:0] w_ext;
  logic [SWR-1:0] h_ext;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row;

  assign w_ext = SWC'(grid_width_q);
  assign h_ext = SWR'(grid_height_q);

  always_comb begin
    if (w_ext == '0) begin
      last_col = '0;
    end else if (w_ext > SWC'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(w_ext - SWC'(1));
    end
    if (h_ext == '0) begin
      last_row = '0;
    end else if (h_ext > SWR'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(h_ext - SWR'(1));
    end
  end

  // ---------------------------------------------------------------- flow
  logic in_ready;
  logic in_xfer;
  logic adv;
  logic s4_valid_q;
  logic out_valid_q;

  // pipeline moves unless a result would land on an untaken one
  assign adv      = !(s4_valid_q && out_valid_q && !result_o.ready);
  assign in_ready = adv;
  assign in_xfer  = cell_i.valid && in_ready;
  assign cell_i.ready = in_ready;

  // ---------------------------------------------------------------- scan position
  logic [CW-1:0] scan_c_q;
  logic [RW-1:0] scan_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_c_q <= '0;
      scan_r_q <= '0;
    end else if (restart) begin
      scan_c_q <= '0;
      scan_r_q <= '0;
    end else if (in_xfer) begin
      if (scan_c_q == last_col) begin
        scan_c_q <= '0;
        scan_r_q <= (scan_r_q == last_row) ? '0 : scan_r_q + RW'(1);
      end else begin
        scan_c_q <= scan_c_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: column sum
  // each line entry holds the last BOX_SIZE-1 cells of its column, oldest lowest
  logic                 s1_valid_q;
  logic [CELL_BITS-1:0] s1_v_q;
  logic [CW-1:0]        s1_c_q;
  logic [RW-1:0]        s1_r_q;
  logic [CLW-1:0]       cell_rd;
  logic [CLW-1:0]       cell_wr;
  logic [CELL_BITS-1:0] cells [2*NP];
  logic [CSW-1:0]       pair_sum [NP];
  logic [CSW-1:0]       colsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_v_q <= CELL_BITS'(cell_i.cell_value);
      s1_c_q <= scan_c_q;
      s1_r_q <= scan_r_q;
    end
  end

  bspl_line_mem #(
    .Depth (MAX_WIDTH),
    .DataW (CLW)
  ) u_cell_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (scan_c_q),
    .wr_en_i   (adv && s1_valid_q),
    .wr_addr_i (s1_c_q),
    .wr_data_i (cell_wr),
    .rd_data_o (cell_rd)
  );

  always_comb begin
    for (int k = 0; k < 2 * NP; k++) begin
      cells[k] = '0;
    end
    for (int k = 0; k < BOX_SIZE - 1; k++) begin
      cells[k] = cell_rd[k*CELL_BITS +: CELL_BITS];
    end
    cells[BOX_SIZE-1] = s1_v_q;
    for (int k = 0; k < NP; k++) begin
      pair_sum[k] = CSW'(cells[2*k]) + CSW'(cells[2*k+1]);
    end
    colsum = '0;
    for (int k = 0; k < NP; k++) begin
      colsum = colsum + pair_sum[k];
    end
  end

  // drop the oldest cell, append the new one
  always_comb begin
    cell_wr = '0;
    for (int k = 0; k < BOX_SIZE - 2; k++) begin
      cell_wr[k*CELL_BITS +: CELL_BITS] = cell_rd[(k+1)*CELL_BITS +: CELL_BITS];
    end
    cell_wr[(BOX_SIZE-2)*CELL_BITS +: CELL_BITS] = s1_v_q;
  end

  // ---------------------------------------------------------------- stage 2: box sum
  // new column sum plus the previous BOX_SIZE-1 column sums
  logic           s2_valid_q;
  logic [CSW-1:0] s2_colsum_q;
  logic [CW-1:0]  s2_c_q;
  logic [RW-1:0]  s2_r_q;
  logic [CSW-1:0] rw_q [BOX_SIZE-1];
  logic [BW-1:0]  box_d;
  logic           box2;
  logic [CW-1:0]  bc2;
  logic [RW-1:0]  br2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_colsum_q <= colsum;
      s2_c_q      <= s1_c_q;
      s2_r_q      <= s1_r_q;
    end
  end

  always_comb begin
    box_d = BW'(s2_colsum_q);
    for (int k = 0; k < BOX_SIZE - 1; k++) begin
      box_d = box_d + BW'(rw_q[k]);
    end
  end

  assign box2  = s2_valid_q && (s2_r_q >= RW'(BOX_SIZE - 1)) && (s2_c_q >= CW'(BOX_SIZE - 1));
  assign bc2   = s2_c_q - CW'(BOX_SIZE - 1);
  assign br2   = s2_r_q - RW'(BOX_SIZE - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BOX_SIZE - 1; k++) begin
        rw_q[k] <= '0;
      end
    end else if (adv && s2_valid_q) begin
      for (int k = 0; k < BOX_SIZE - 2; k++) begin
        rw_q[k] <= rw_q[k+1];
      end
      rw_q[BOX_SIZE-2] <= s2_colsum_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: pool column
  // box line entry holds the last POOL_SIZE-1 box sums of its column, oldest lowest
  logic           s3_valid_q;
  logic [BW-1:0]  s3_box_q;
  logic [CW-1:0]  s3_bc_q;
  logic [RW-1:0]  s3_br_q;
  logic [BLW-1:0] box_rd;
  logic [BLW-1:0] box_wr;
  logic [BW-1:0]  vals [POOL_SIZE];
  logic [KW-1:0]  colkey_new;
  logic [KW-1:0]  colkey_q [POOL_SIZE];
  logic           res3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= box2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_box_q <= box_d;
      s3_bc_q  <= bc2;
      s3_br_q  <= br2;
    end
  end

  bspl_line_mem #(
    .Depth (MAX_WIDTH),
    .DataW (BLW)
  ) u_box_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv && box2),
    .rd_addr_i (bc2),
    .wr_en_i   (adv && s3_valid_q),
    .wr_addr_i (s3_bc_q),
    .wr_data_i (box_wr),
    .rd_data_o (box_rd)
  );

  always_comb begin
    box_wr = '0;
    for (int i = 0; i < POOL_SIZE - 2; i++) begin
      box_wr[i*BW +: BW] = box_rd[(i+1)*BW +: BW];
    end
    box_wr[(POOL_SIZE-2)*BW +: BW] = s3_box_q;
    for (int i = 0; i < POOL_SIZE - 1; i++) begin
      vals[i] = box_rd[i*BW +: BW];
    end
    vals[POOL_SIZE-1] = s3_box_q;
  end

  // column peak, key carries the row so ties fall to the higher row
  always_comb begin
    colkey_new = {vals[0], IW'(0)};
    for (int i = 1; i < POOL_SIZE; i++) begin
      if ({vals[i], IW'(i)} > colkey_new) begin
        colkey_new = {vals[i], IW'(i)};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      for (int j = 0; j < POOL_SIZE - 1; j++) begin
        colkey_q[j] <= colkey_q[j+1];
      end
      colkey_q[POOL_SIZE-1] <= colkey_new;
    end
  end

  assign res3 = s3_valid_q && (s3_br_q >= RW'(POOL_SIZE - 1)) &&
                (s3_bc_q >= CW'(POOL_SIZE - 1));

  // ---------------------------------------------------------------- stage 4: window peak
  logic [RW-1:0]   s4_pr_q;
  logic [CW-1:0]   s4_pc_q;
  logic [WK-1:0]   best;
  logic [BW-1:0]   best_val;
  logic [IW-1:0]   best_i;
  logic [IW-1:0]   best_j;
  logic            found;
  logic [RW-1:0]   lead_row;
  logic [CW-1:0]   lead_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= res3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pr_q <= s3_br_q - RW'(POOL_SIZE - 1);
      s4_pc_q <= s3_bc_q - CW'(POOL_SIZE - 1);
    end
  end

  // key order value, row, column picks the last peak in raster order
  always_comb begin
    best = {colkey_q[0], IW'(0)};
    for (int j = 1; j < POOL_SIZE; j++) begin
      if ({colkey_q[j], IW'(j)} > best) begin
        best = {colkey_q[j], IW'(j)};
      end
    end
  end

  assign best_val = best[WK-1 -: BW];
  assign best_i   = best[2*IW-1 -: IW];
  assign best_j   = best[IW-1:0];
  assign found    = PW'(best_val) >= PW'(min_pop_q);
  assign lead_row = s4_pr_q + RW'(best_i);
  assign lead_col = s4_pc_q + CW'(best_j);

  // ---------------------------------------------------------------- output register
  logic [COORD_W-1:0]    out_wrow_q;
  logic [COORD_W-1:0]    out_wcol_q;
  logic                  out_found_q;
  logic [COORD_W-1:0]    out_lrow_q;
  logic [COORD_W-1:0]    out_lcol_q;
  logic [PEAK_SUM_W-1:0] out_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s4_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_valid_q) begin
      out_wrow_q  <= COORD_W'(s4_pr_q);
      out_wcol_q  <= COORD_W'(s4_pc_q);
      out_found_q <= found;
      out_lrow_q  <= found ? COORD_W'(lead_row) : '0;
      out_lcol_q  <= found ? COORD_W'(lead_col) : '0;
      out_peak_q  <= PEAK_SUM_W'(best_val);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.window_row   = out_wrow_q;
  assign result_o.window_col   = out_wcol_q;
  assign result_o.leader_found = out_found_q;
  assign result_o.leader_row   = out_lrow_q;
  assign result_o.leader_col   = out_lcol_q;
  assign result_o.peak_sum     = out_peak_q;

  // ---------------------------------------------------------------- checks
  `BSPL_ASSERT_IMP(a_no_overrun, s4_valid_q && out_valid_q && !result_o.ready, !in_ready, "result would overwrite untaken result")
  `BSPL_ASSERT(a_scan_in_grid, (scan_c_q <= last_col) && (scan_r_q <= last_row), "scan position outside grid")
  `BSPL_ASSERT_IMP(a_out_from_window, $rose(out_valid_q), $past(s4_valid_q), "result without finished window")

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
  import bspl_pkg::*;

  localparam int BOX   = BOX_SIZE_DEF;
  localparam int POOL  = POOL_SIZE_DEF;
  localparam int MAXW  = MAX_WIDTH_DEF;
  localparam int MAXH  = MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam int ITEM_TARGET = 1350;
  // margin for the pipeline stages and output register after the last cell
  localparam int SETTLE_CYCLES = 16;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // cell pattern kinds
  typedef enum int {CELLS_RANDOM, CELLS_FULL, CELLS_ZERO, CELLS_SPARSE} cell_pattern_e;

  typedef struct packed {
    logic [COORD_W-1:0]    window_row;
    logic [COORD_W-1:0]    window_col;
    logic                  leader_found;
    logic [COORD_W-1:0]    leader_row;
    logic [COORD_W-1:0]    leader_col;
    logic [PEAK_SUM_W-1:0] peak_sum;
  } peak_report_t;

  // bit accurate copy of the box filter, max pool and argmax path
  class peak_scoreboard;
    logic [DIM_W-1:0]     height_reg;
    logic [DIM_W-1:0]     width_reg;
    logic [MIN_POP_W-1:0] min_pop_reg;
    logic [7:0]  cell_lines [BOX-1][MAXW];
    logic [11:0] row_sums   [BOX];
    logic [14:0] box_lines  [POOL-1][MAXW];
    logic [14:0] pool_win   [POOL][POOL];
    int scan_r, scan_c;
    peak_report_t expected_peaks[$];

    function new();
      height_reg  = GRID_HEIGHT_RST;
      width_reg   = GRID_WIDTH_RST;
      min_pop_reg = MIN_POP_RST;
      foreach (cell_lines[i, j]) cell_lines[i][j] = '0;
      foreach (box_lines[i, j]) box_lines[i][j] = '0;
      foreach (row_sums[i]) row_sums[i] = '0;
      foreach (pool_win[i, j]) pool_win[i][j] = '0;
      scan_r = 0;
      scan_c = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_HEIGHT: begin
          height_reg = data[DIM_W-1:0];
          scan_r = 0;
          scan_c = 0;
        end
        REG_GRID_WIDTH: begin
          width_reg = data[DIM_W-1:0];
          scan_r = 0;
          scan_c = 0;
        end
        REG_MIN_POP: min_pop_reg = data[MIN_POP_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted cell transfer
    function void note_cell(logic [CELL_VALUE_W-1:0] v);
      int w, h, r, c, colsum, box, br, bc, best, best_r, best_c;
      peak_report_t p;
      w = (width_reg < 1) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
      h = (height_reg < 1) ? 1 : (height_reg > MAXH) ? MAXH : height_reg;
      r = scan_r;
      c = scan_c % MAXW;
      colsum = v;
      for (int k = 0; k < BOX - 1; k++) colsum += cell_lines[k][c];
      cell_lines[r % (BOX - 1)][c] = v;
      for (int k = 0; k < BOX - 1; k++) row_sums[k] = row_sums[k + 1];
      row_sums[BOX - 1] = colsum[11:0];
      if (r >= BOX - 1 && c >= BOX - 1) begin
        br = r - (BOX - 1);
        bc = c - (BOX - 1);
        box = 0;
        for (int k = 0; k < BOX; k++) box += row_sums[k];
        for (int i = 0; i < POOL; i++)
          for (int j = 0; j < POOL - 1; j++) pool_win[i][j] = pool_win[i][j + 1];
        for (int i = 0; i < POOL - 1; i++)
          pool_win[i][POOL - 1] = box_lines[(br + i) % (POOL - 1)][bc];
        pool_win[POOL - 1][POOL - 1] = box[14:0];
        box_lines[br % (POOL - 1)][bc] = box[14:0];
        if (br >= POOL - 1 && bc >= POOL - 1) begin
          best = 0;
          best_r = br - (POOL - 1);
          best_c = bc - (POOL - 1);
          // ties go to the later box sum in raster order
          for (int i = 0; i < POOL; i++)
            for (int j = 0; j < POOL; j++)
              if (pool_win[i][j] >= best) begin
                best = pool_win[i][j];
                best_r = br - (POOL - 1) + i;
                best_c = bc - (POOL - 1) + j;
              end
          p.window_row   = 8'(br - (POOL - 1));
          p.window_col   = 8'(bc - (POOL - 1));
          p.leader_found = (best >= min_pop_reg);
          p.leader_row   = p.leader_found ? 8'(best_r) : 8'd0;
          p.leader_col   = p.leader_found ? 8'(best_c) : 8'd0;
          p.peak_sum     = 15'(best);
          expected_peaks = {expected_peaks, p};
        end
      end
      scan_c = c + 1;
      if (scan_c >= w) begin
        scan_c = 0;
        scan_r = r + 1;
        if (scan_r >= h) scan_r = 0;
      end
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(peak_report_t got);
      peak_report_t exp;
      string msg;
      if (expected_peaks.size() == 0)
        return $sformatf("result with nothing pending: window (%0d,%0d)",
                         got.window_row, got.window_col);
      exp = expected_peaks.pop_front();
      msg = "";
      if (got.window_row !== exp.window_row)
        msg = {msg, $sformatf(" window_row %0d/%0d", got.window_row, exp.window_row)};
      if (got.window_col !== exp.window_col)
        msg = {msg, $sformatf(" window_col %0d/%0d", got.window_col, exp.window_col)};
      if (got.leader_found !== exp.leader_found)
        msg = {msg, $sformatf(" leader_found %0d/%0d", got.leader_found, exp.leader_found)};
      if (got.leader_row !== exp.leader_row)
        msg = {msg, $sformatf(" leader_row %0d/%0d", got.leader_row, exp.leader_row)};
      if (got.leader_col !== exp.leader_col)
        msg = {msg, $sformatf(" leader_col %0d/%0d", got.leader_col, exp.leader_col)};
      if (got.peak_sum !== exp.peak_sum)
        msg = {msg, $sformatf(" peak_sum %0d/%0d", got.peak_sum, exp.peak_sum)};
      if (msg != "")
        msg = {$sformatf("window (%0d,%0d) got/exp:", exp.window_row, exp.window_col), msg};
      return msg;
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bspl_cell_if   cell_ch ();
  bspl_result_if result_ch ();

  box_sum_peak_locator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_i     (cell_ch),
    .result_o   (result_ch)
  );

  peak_scoreboard sb = new();
  int  mismatches = 0;
  int  cycles = 0;
  int  sent_cells = 0;
  bit  idle_sender = 1'b1;   // sender gaps on or off for the phase
  bit  sink_stalls = 1'b1;   // receiver stalls on or off for the phase
  bit  pressure_go = 1'b0;   // arms the long receiver hold-off
  bit  holdoff = 1'b0;

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_sum_peak_locator_unit regression: fail");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // receiver: short random stalls, a few long ones, and the hold-off
  always @(posedge clk_i) begin : sink_ready
    static int stall_left = 0;
    int roll;
    roll = $urandom_range(0, 199);
    if (!rst_ni || holdoff) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!sink_stalls) begin
      result_ch.ready <= 1'b1;
    end else begin
      if (roll < 2) stall_left = $urandom_range(15, 60);
      result_ch.ready <= (roll >= 50);
    end
  end

  // long hold-off once a result is on its way, while cells keep coming
  initial begin : pressure
    wait (pressure_go);
    @(posedge clk_i);
    while (sb.pending() < 1) @(posedge clk_i);
    holdoff = 1'b1;
    repeat (400) @(posedge clk_i);
    holdoff = 1'b0;
  end

  // result transfers are checked mid-cycle, where both sides are stable
  always @(negedge clk_i) begin
    peak_report_t got;
    string msg;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got.window_row   = result_ch.window_row;
      got.window_col   = result_ch.window_col;
      got.leader_found = result_ch.leader_found;
      got.leader_row   = result_ch.leader_row;
      got.leader_col   = result_ch.leader_col;
      got.peak_sum     = result_ch.peak_sum;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  // called at a rising edge, returns at the edge of the transfer or after an idle gap
  task automatic send_cell(logic [CELL_VALUE_W-1:0] v);
    int roll;
    cell_ch.valid <= 1'b1;
    cell_ch.cell_value <= v;
    do @(negedge clk_i); while (!cell_ch.ready);
    sb.note_cell(v);
    sent_cells++;
    @(posedge clk_i);
    roll = $urandom_range(0, 99);
    if (idle_sender && roll >= 70) begin
      cell_ch.valid <= 1'b0;
      repeat (roll >= 96 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every expected result has come, then let the pipe empty
  task automatic drain();
    cell_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_grid(int hgt, int wid, int min_pop, cell_pattern_e pattern, int count);
    logic [CELL_VALUE_W-1:0] v;
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(hgt));
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(wid));
    write_reg(REG_MIN_POP, CFG_DATA_W'(min_pop));
    for (int n = 0; n < count; n++) begin
      case (pattern)
        CELLS_FULL:   v = 8'hff;
        CELLS_ZERO:   v = 8'h00;
        CELLS_SPARSE: v = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        default:      v = 8'($urandom);
      endcase
      send_cell(v);
    end
    drain();
  endtask

  initial begin : stimulus
    int hgt, wid, mp, cnt;
    cell_ch.valid = 1'b0;
    cell_ch.cell_value = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write to an index with no register, must be ignored
    write_reg(REG_UNUSED, 15'h7fff);
    // all cells full: peak at the ceiling, ties resolve to the last box
    run_grid(13, 13, 25500, CELLS_FULL, 169);
    // all cells empty with zero threshold: found, zero peak
    run_grid(14, 13, 0, CELLS_ZERO, 182);
    // all empty with threshold one: not found
    run_grid(13, 13, 1, CELLS_ZERO, 169);
    // height clamps to one row: no results, then the scan wraps
    run_grid(0, 20, 15, CELLS_RANDOM, 40);
    // oversize width clamps to the maximum, scan wraps past the last column
    idle_sender = 1'b0;
    sink_stalls = 1'b0;
    run_grid(13, 300, 15, CELLS_RANDOM, MAXW + 20);
    idle_sender = 1'b1;
    sink_stalls = 1'b1;
    // receiver hold-off while the sender keeps offering
    pressure_go = 1'b1;
    run_grid(16, 16, 500, CELLS_RANDOM, 16 * 16);

    while (sent_cells < ITEM_TARGET) begin
      hgt = $urandom_range(13, 16);
      wid = $urandom_range(13, 18);
      mp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 2000);
      // mostly whole grids, sometimes two, sometimes cut short by the next size write
      case ($urandom_range(0, 3))
        0:       cnt = $urandom_range(1, hgt * wid - 1);
        1:       cnt = 2 * hgt * wid;
        default: cnt = hgt * wid;
      endcase
      if (cnt > ITEM_TARGET + 100 - sent_cells) cnt = ITEM_TARGET + 100 - sent_cells;
      idle_sender = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      run_grid(hgt, wid, mp, ($urandom_range(0, 2) == 0) ? CELLS_SPARSE : CELLS_RANDOM, cnt);
    end

    if (sb.pending() != 0) report("expected results left over");
    if (mismatches == 0) begin
      $display("box_sum_peak_locator_unit regression: pass");
    end else begin
      $display("box_sum_peak_locator_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/bspl_pkg.sv
hw/rtl/bspl_cell_if.sv
hw/rtl/bspl_result_if.sv
hw/rtl/bspl_line_mem.sv
hw/rtl/box_sum_peak_locator_unit.sv
sim/testbench.sv
